// ----- rtl/esckd_pkg.sv -----
// Shared types, key codes and lookup functions for the escape sequence key decoder.
// No dependencies.
`default_nettype none

package esckd_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned KeyW  = 9;

   localparam logic [ByteW-1:0] ChrEsc     = 8'h1b;
   localparam logic [ByteW-1:0] ChrTilde   = 8'h7e;
   localparam logic [ByteW-1:0] ChrBracket = 8'h5b;
   localparam logic [ByteW-1:0] ChrO       = 8'h4f;
   localparam logic [ByteW-1:0] ChrZero    = 8'h30;
   localparam logic [ByteW-1:0] ChrNine    = 8'h39;
   localparam logic [ByteW-1:0] ChrA       = 8'h41;
   localparam logic [ByteW-1:0] ChrB       = 8'h42;
   localparam logic [ByteW-1:0] ChrC       = 8'h43;
   localparam logic [ByteW-1:0] ChrD       = 8'h44;
   localparam logic [ByteW-1:0] ChrF       = 8'h46;
   localparam logic [ByteW-1:0] ChrH       = 8'h48;

   localparam logic [KeyW-1:0] KeyEsc    = 9'd27;
   localparam logic [KeyW-1:0] KeyLeft   = 9'd256;
   localparam logic [KeyW-1:0] KeyRight  = 9'd257;
   localparam logic [KeyW-1:0] KeyUp     = 9'd258;
   localparam logic [KeyW-1:0] KeyDown   = 9'd259;
   localparam logic [KeyW-1:0] KeyDelete = 9'd260;
   localparam logic [KeyW-1:0] KeyHome   = 9'd261;
   localparam logic [KeyW-1:0] KeyEnd    = 9'd262;
   localparam logic [KeyW-1:0] KeyPgUp   = 9'd263;
   localparam logic [KeyW-1:0] KeyPgDn   = 9'd264;

   localparam logic CmdByte    = 1'b0;
   localparam logic CmdTimeout = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_ESC   = 4'b0010,
      PH_FIRST = 4'b0100,
      PH_DIGIT = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      CLS_OTHER   = 3'b001,
      CLS_BRACKET = 3'b010,
      CLS_O       = 3'b100
   } class_type;

   typedef struct packed {
      logic             vld;
      logic             cmd;
      logic [ByteW-1:0] byte_value;
   } item_type;

   typedef struct packed {
      logic            vld;
      logic [KeyW-1:0] key_code;
   } result_type;

   function automatic logic [KeyW-1:0] bracket_key(input logic [ByteW-1:0] b);
      logic [KeyW-1:0] k;
      case (b)
         ChrA:    k = KeyUp;
         ChrB:    k = KeyDown;
         ChrC:    k = KeyRight;
         ChrD:    k = KeyLeft;
         ChrH:    k = KeyHome;
         ChrF:    k = KeyEnd;
         default: k = KeyEsc;
      endcase
      return k;
   endfunction

   function automatic logic [KeyW-1:0] tilde_key(input logic [3:0] d);
      logic [KeyW-1:0] k;
      case (d)
         4'd1, 4'd7: k = KeyHome;
         4'd3:       k = KeyDelete;
         4'd4, 4'd8: k = KeyEnd;
         4'd5:       k = KeyPgUp;
         4'd6:       k = KeyPgDn;
         default:    k = KeyEsc;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/escape_sequence_key_decoder.sv -----
// Escape sequence key decoder, top level: input register, decoder, result register.
// Depends on esckd_pkg, esckd_in_reg, esckd_decode, esckd_out_reg.
//
// Usage:
//   Request channel (req_valid/req_stall): one beat per received terminal byte
//   (req_cmd = 0, req_byte_value) or read timeout (req_cmd = 1).
//   Response channel (rsp_valid/rsp_stall): one key code beat per plain byte,
//   completed or failed escape sequence; bytes inside a sequence give none.
//   A key code passes from the input register through the decoder into the
//   result register, which presents it on rsp_valid and rsp_key_code.
//   Throughput: one request beat per cycle while the receiver does not stall,
//   set by the single decode stage between the input and result registers.
//   When the receiver stalls, the result register holds its beat and the
//   input register can still take one more request beat; after that
//   req_stall rises until the result is taken.
//   Reset (synchronous, active high) empties both registers and returns the
//   sequence state to idle.
`default_nettype none

module escape_sequence_key_decoder (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_cmd,
   input  wire  [esckd_pkg::ByteW-1:0]  req_byte_value,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [esckd_pkg::KeyW-1:0]   rsp_key_code
);
   import esckd_pkg::*;

   item_type   item;
   result_type res;
   logic       adv;

   esckd_in_reg u_in (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_byte_value (req_byte_value),
      .adv            (adv),
      .item           (item)
   );

   esckd_decode u_dec (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .adv   (adv),
      .res   (res)
   );

   esckd_out_reg u_out (
      .clock        (clock),
      .reset        (reset),
      .res          (res),
      .adv          (adv),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_key_code (rsp_key_code)
   );

endmodule

`default_nettype wire

// ----- rtl/esckd_in_reg.sv -----
// Input register for the key decoder: captures one request beat.
// Depends on esckd_pkg.
`default_nettype none

module esckd_in_reg (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_cmd,
   input  wire  [esckd_pkg::ByteW-1:0]  req_byte_value,
   input  wire                          adv,
   output esckd_pkg::item_type          item
);
   import esckd_pkg::*;

   logic             vld_ff, vld_in;
   logic             cmd_ff, cmd_in;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic             take;

   assign req_stall = vld_ff & ~adv;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      vld_in  = take | (vld_ff & ~adv);
      cmd_in  = take ? req_cmd : cmd_ff;
      byte_in = take ? req_byte_value : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
   end

   assign item = '{vld: vld_ff, cmd: cmd_ff, byte_value: byte_ff};

endmodule

`default_nettype wire

// ----- rtl/esckd_decode.sv -----
// Sequence state machine and key lookup for the key decoder.
// Depends on esckd_pkg.
`default_nettype none

module esckd_decode (
   input  wire                   clock,
   input  wire                   reset,
   input  esckd_pkg::item_type   item,
   input  wire                   adv,
   output esckd_pkg::result_type res
);
   import esckd_pkg::*;

   phase_type       phase_ff, phase_in;
   class_type       cls_ff, cls_in;
   logic [3:0]      digit_ff, digit_in;
   logic            emit;
   logic [KeyW-1:0] key;
   logic            go;
   logic            is_digit;
   logic [ByteW-1:0] b;

   assign go       = item.vld & adv;
   assign b        = item.byte_value;
   assign is_digit = (b >= ChrZero) && (b <= ChrNine);

   always_comb begin
      phase_in = phase_ff;
      cls_in   = cls_ff;
      digit_in = digit_ff;
      emit     = 1'b0;
      key      = KeyEsc;
      if (go) begin
         case (phase_ff)
            PH_IDLE: begin
               if (item.cmd == CmdByte) begin
                  if (b == ChrEsc) begin
                     phase_in = PH_ESC;
                  end else begin
                     emit = 1'b1;
                     key  = {1'b0, b};
                  end
               end
            end
            PH_ESC: begin
               if (item.cmd == CmdTimeout) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_FIRST;
                  cls_in   = (b == ChrBracket) ? CLS_BRACKET :
                             (b == ChrO)       ? CLS_O : CLS_OTHER;
               end
            end
            PH_FIRST: begin
               if (item.cmd == CmdTimeout) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end else if (cls_ff == CLS_BRACKET && is_digit) begin
                  phase_in = PH_DIGIT;
                  digit_in = b[3:0];
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
                  case (cls_ff)
                     CLS_BRACKET: key = bracket_key(b);
                     CLS_O:       key = (b == ChrH) ? KeyHome :
                                        (b == ChrF) ? KeyEnd : KeyEsc;
                     default:     key = KeyEsc;
                  endcase
               end
            end
            PH_DIGIT: begin
               emit     = 1'b1;
               phase_in = PH_IDLE;
               if (item.cmd == CmdByte && b == ChrTilde) begin
                  key = tilde_key(digit_ff);
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cls_ff   <= CLS_OTHER;
         digit_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         cls_ff   <= cls_in;
         digit_ff <= digit_in;
      end
   end

   assign res = '{vld: emit, key_code: key};

   a_emit_needs_beat: assert property (@(posedge clock) disable iff (reset)
      emit |-> go)
      else $error("key emitted without an advancing beat");

   a_idle_byte_emits: assert property (@(posedge clock) disable iff (reset)
      (go && phase_ff == PH_IDLE && item.cmd == CmdByte && b != ChrEsc) |-> emit)
      else $error("plain byte in idle not emitted");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      emit |-> (key <= KeyPgDn))
      else $error("key code out of range");

   a_digit_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGIT) |-> ($past(phase_ff) == PH_DIGIT || $past(phase_ff) == PH_FIRST))
      else $error("digit phase entered from wrong phase");

endmodule

`default_nettype wire

// ----- rtl/esckd_out_reg.sv -----
// Result register for the key decoder: holds one key code beat until taken.
// Depends on esckd_pkg.
`default_nettype none

module esckd_out_reg (
   input  wire                          clock,
   input  wire                          reset,
   input  esckd_pkg::result_type        res,
   output logic                         adv,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [esckd_pkg::KeyW-1:0]   rsp_key_code
);
   import esckd_pkg::*;

   logic            vld_ff, vld_in;
   logic [KeyW-1:0] key_ff, key_in;

   assign adv = ~(vld_ff & rsp_stall);

   always_comb begin
      vld_in = res.vld | (vld_ff & rsp_stall);
      key_in = res.vld ? res.key_code : key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      key_ff <= key_in;
   end

   assign rsp_valid    = vld_ff;
   assign rsp_key_code = key_ff;

endmodule

`default_nettype wire
